// ----- hdl/round_robin_job_scheduler_core_macros.svh -----
// Assertion macros for the round-robin job scheduler core.
// Used by the top level; clk and rst_n must be in scope where expanded.
`ifndef ROUND_ROBIN_JOB_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_JOB_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RRJS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RRJS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RRJS_ASSERT_IMP(lbl, ante, cons, msg)
`define RRJS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/rrjs_pkg.sv -----
// Shared types, codes and constants of the round-robin job scheduler.
// No dependencies; used by every module of the block.
`default_nettype none
package rrjs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int LIST_W          = $clog2(MAX_RESULTS + 1);
  localparam int NUM_W           = 47;
  localparam int DEN_W           = 32;
  localparam logic [13:0] HUND_SCALE = 14'd10000;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_LIST = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [2:0] ST_IDLE_TICK  = 3'd0;
  localparam logic [2:0] ST_BUSY_TICK  = 3'd1;
  localparam logic [2:0] ST_JOB_DONE   = 3'd2;
  localparam logic [2:0] ST_ADDED      = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
  localparam logic [2:0] ST_LIST_ENTRY = 3'd6;
  localparam logic [2:0] ST_LIST_EMPTY = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] job_id;
    logic [15:0] job_cycles;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] time_now;
    logic [15:0] job_id_out;
    logic [15:0] remaining;
    logic [31:0] elapsed;
    logic [31:0] idle_cycles;
    logic [13:0] idle_hundredths;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] start;
    logic [15:0] total;
    logic [15:0] left;
  } job_t;

  typedef struct packed {
    logic       cap_in;
    logic       rd_en;
    logic       rd_list;
    logic       calc;
    logic       mul;
    logic       div_start;
    logic       list_clr;
    logic       list_step;
    logic       emit;
    logic [2:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       count_zero;
    logic       count_full;
    logic       cyc_zero;
    logic       job_done;
    logic       el_zero;
    logic       div_done;
    logic       list_last;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- hdl/rrjs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the idle percentage.
// Depends on rrjs_pkg for operand widths.
`default_nettype none
module rrjs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rrjs_pkg::NUM_W-1:0]  num,
  input  wire logic [rrjs_pkg::DEN_W-1:0]  den,
  output logic                             done,
  output logic [rrjs_pkg::NUM_W-1:0]       quo
);

  localparam int NW    = rrjs_pkg::NUM_W;
  localparam int DW    = rrjs_pkg::DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    sh_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;
  logic [DW-1:0]    rem_nxt;

  assign trial   = {rem_r, sh_r[NW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign fits    = trial >= {1'b0, den_r};
  // remainder stays below the divisor, so it fits in DW bits
  assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[NW-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- hdl/rrjs_dpath.sv -----
// Datapath: job queue memory, clock, head and count, statistics, output register.
// Depends on rrjs_pkg and rrjs_div; driven by rrjs_ctrl commands.
`default_nettype none
module rrjs_dpath #(
  parameter int QUEUE_DEPTH = rrjs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rrjs_pkg::in_t  in_data,
  input  wire logic           out_stall,
  output logic                out_valid,
  output rrjs_pkg::out_t      out_data,
  input  wire rrjs_pkg::cmd_t cmd,
  output rrjs_pkg::stat_t     stat
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = rrjs_pkg::LIST_W;
  localparam int SW = ((CW > LW) ? CW : LW) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
  localparam logic [SW-1:0] MAX_S = SW'(rrjs_pkg::MAX_RESULTS);

  function automatic logic [IW-1:0] wrap_slot(input logic [SW-1:0] s);
    return (s >= DEPTH_S) ? IW'(s - DEPTH_S) : IW'(s);
  endfunction

  rrjs_pkg::job_t mem [QUEUE_DEPTH];
  rrjs_pkg::job_t rdata_r;
  rrjs_pkg::job_t wdata;
  rrjs_pkg::in_t  in_r;
  rrjs_pkg::out_t out_r;
  rrjs_pkg::out_t out_nxt;

  logic [31:0]             clock_time_r;
  logic [IW-1:0]           head_r;
  logic [CW-1:0]           count_r;
  logic [LW-1:0]           idx_r;
  logic                    out_valid_r;
  logic [31:0]             el_r;
  logic [31:0]             idle_r;
  logic [15:0]             left_r;
  logic [rrjs_pkg::NUM_W-1:0] num_r;

  logic [IW-1:0]           tail_slot;
  logic [IW-1:0]           list_slot;
  logic [IW-1:0]           raddr;
  logic [IW-1:0]           head_inc;
  logic                    wr_en;
  logic                    tick_adv;
  logic [SW-1:0]           n_lim;
  logic [31:0]             el_calc;
  logic [45:0]             prod_w;
  logic                    div_done;
  logic [rrjs_pkg::NUM_W-1:0] quo;
  logic [13:0]             hund;
  logic                    out_free;

  assign tail_slot = wrap_slot(SW'(head_r) + SW'(count_r));
  assign list_slot = wrap_slot(SW'(head_r) + SW'(idx_r));
  assign raddr     = cmd.rd_list ? list_slot : head_r;
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign n_lim     = (SW'(count_r) > MAX_S) ? MAX_S : SW'(count_r);
  assign out_free  = !out_valid_r || !out_stall;

  assign wr_en = cmd.emit && ((cmd.emit_status == rrjs_pkg::ST_BUSY_TICK) ||
                              (cmd.emit_status == rrjs_pkg::ST_ADDED));
  assign tick_adv = cmd.emit && ((cmd.emit_status == rrjs_pkg::ST_IDLE_TICK) ||
                                 (cmd.emit_status == rrjs_pkg::ST_BUSY_TICK) ||
                                 (cmd.emit_status == rrjs_pkg::ST_JOB_DONE));

  always_comb begin
    if (cmd.emit_status == rrjs_pkg::ST_ADDED) begin
      wdata.id    = in_r.job_id;
      wdata.start = clock_time_r;
      wdata.total = in_r.job_cycles;
      wdata.left  = in_r.job_cycles;
    end else begin
      wdata      = rdata_r;
      wdata.left = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_slot] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_time_r <= '0;
      head_r       <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (tick_adv) begin
        clock_time_r <= clock_time_r + 32'd1;
      end
      if (cmd.emit) begin
        unique case (cmd.emit_status)
          rrjs_pkg::ST_BUSY_TICK: head_r <= head_inc;
          rrjs_pkg::ST_JOB_DONE: begin
            head_r  <= head_inc;
            count_r <= count_r - 1'b1;
          end
          rrjs_pkg::ST_ADDED: count_r <= count_r + 1'b1;
          default: ;
        endcase
      end
      if (cmd.list_clr) begin
        idx_r <= '0;
      end else if (cmd.list_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // decrement the head job's cycles and take its statistics
  assign el_calc = clock_time_r - rdata_r.start + 32'd1;
  assign prod_w  = 46'(idle_r) * 46'(rrjs_pkg::HUND_SCALE);

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_data;
    end
    if (cmd.calc) begin
      el_r   <= el_calc;
      idle_r <= el_calc - 32'(rdata_r.total);
      left_r <= (rdata_r.left == 16'd0) ? 16'd0 : rdata_r.left - 16'd1;
    end
    if (cmd.mul) begin
      num_r <= {1'b0, prod_w} + rrjs_pkg::NUM_W'(el_r[31:1]);
    end
  end

  rrjs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (el_r),
    .done  (div_done),
    .quo   (quo)
  );

  // saturate the quotient; a wrapped-to-zero elapsed count gives zero
  assign hund = (el_r == 32'd0) ? 14'd0 :
                (quo > rrjs_pkg::NUM_W'(rrjs_pkg::HUND_SCALE)) ? rrjs_pkg::HUND_SCALE :
                quo[13:0];

  always_comb begin
    out_nxt          = '0;
    out_nxt.status   = cmd.emit_status;
    out_nxt.time_now = clock_time_r;
    out_nxt.last     = 1'b1;
    unique case (cmd.emit_status)
      rrjs_pkg::ST_BUSY_TICK: begin
        out_nxt.job_id_out = rdata_r.id;
        out_nxt.remaining  = left_r;
      end
      rrjs_pkg::ST_JOB_DONE: begin
        out_nxt.job_id_out      = rdata_r.id;
        out_nxt.elapsed         = el_r;
        out_nxt.idle_cycles     = idle_r;
        out_nxt.idle_hundredths = hund;
      end
      rrjs_pkg::ST_ADDED, rrjs_pkg::ST_FULL: begin
        out_nxt.job_id_out = in_r.job_id;
        out_nxt.remaining  = in_r.job_cycles;
      end
      rrjs_pkg::ST_BAD_LENGTH: out_nxt.job_id_out = in_r.job_id;
      rrjs_pkg::ST_LIST_ENTRY: begin
        out_nxt.job_id_out = rdata_r.id;
        out_nxt.remaining  = rdata_r.left;
        out_nxt.last       = stat.list_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.mode       = in_r.mode;
  assign stat.count_zero = (count_r == '0);
  assign stat.count_full = (count_r >= DEPTH_C);
  assign stat.cyc_zero   = (in_r.job_cycles == 16'd0);
  assign stat.job_done   = (left_r == 16'd0);
  assign stat.el_zero    = (el_r == 32'd0);
  assign stat.div_done   = div_done;
  assign stat.list_last  = ((SW'(idx_r) + SW'(1)) == n_lim);
  assign stat.out_free   = out_free;

endmodule
`default_nettype wire

// ----- hdl/rrjs_ctrl.sv -----
// Controller state machine: sequences one input item through the datapath.
// Depends on rrjs_pkg; talks to rrjs_dpath through command and status structs.
`default_nettype none
module rrjs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire rrjs_pkg::stat_t stat,
  output rrjs_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_LRD   = 4'd7;
  localparam logic [3:0] S_LEMIT = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [2:0] st_r;
  logic [2:0] st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.mode)
          rrjs_pkg::MODE_TICK: begin
            if (stat.count_zero) begin
              st_nxt    = rrjs_pkg::ST_IDLE_TICK;
              state_nxt = S_EMIT;
            end else begin
              cmd.rd_en = 1'b1;
              state_nxt = S_RD;
            end
          end
          rrjs_pkg::MODE_ADD: begin
            // length check takes priority over the full check
            if (stat.cyc_zero) begin
              st_nxt = rrjs_pkg::ST_BAD_LENGTH;
            end else if (stat.count_full) begin
              st_nxt = rrjs_pkg::ST_FULL;
            end else begin
              st_nxt = rrjs_pkg::ST_ADDED;
            end
            state_nxt = S_EMIT;
          end
          rrjs_pkg::MODE_LIST: begin
            if (stat.count_zero) begin
              st_nxt    = rrjs_pkg::ST_LIST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.list_clr = 1'b1;
              state_nxt    = S_LRD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin
        cmd.calc  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!stat.job_done) begin
          st_nxt    = rrjs_pkg::ST_BUSY_TICK;
          state_nxt = S_EMIT;
        end else if (stat.el_zero) begin
          st_nxt    = rrjs_pkg::ST_JOB_DONE;
          state_nxt = S_EMIT;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          st_nxt    = rrjs_pkg::ST_JOB_DONE;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_status = st_r;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_list = 1'b1;
        state_nxt   = S_LEMIT;
      end
      S_LEMIT: begin
        cmd.emit_status = rrjs_pkg::ST_LIST_ENTRY;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.list_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.list_step = 1'b1;
            state_nxt     = S_LRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= rrjs_pkg::ST_IDLE_TICK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ----- hdl/round_robin_job_scheduler_core.sv -----
// Round-robin job scheduler core: one item at a time, accept to result register.
// Add, refused add, idle tick and empty list pass decode and emit; a busy tick also reads
// and updates the head job; job done adds a restoring divide for the idle percentage;
// a list emits one result per entry, with one memory read per entry.
// Throughput: the next item is taken in the cycle its predecessor's last result goes valid.
// Reset (rst_n, synchronous): clock, head and count cleared; queue memory is not.
`default_nettype none
`include "round_robin_job_scheduler_core_macros.svh"
module round_robin_job_scheduler_core #(
  parameter int QUEUE_DEPTH = rrjs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rrjs_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rrjs_pkg::out_t      out_data
);

  rrjs_pkg::cmd_t  cmd;
  rrjs_pkg::stat_t stat;

  rrjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrjs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  `RRJS_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free, "result loaded over pending transfer")
  `RRJS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not held off")
  `RRJS_ASSERT_NXT(a_no_back_to_back_emit, cmd.emit, !cmd.emit, "two results in adjacent cycles")

endmodule
`default_nettype wire

// ----- dv/round_robin_job_scheduler_checker.sv -----
// Checker for the round-robin job scheduler core: watches both channels,
// predicts every result from its own copy of the queue and compares it.
// Depends on rrjs_pkg for the payload types, modes and status codes.
`timescale 1ns / 100ps
module round_robin_job_scheduler_checker
  import rrjs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   mismatches,
  output int   results_outstanding,
  output int   results_checked,
  output int   jobs_finished
);

  localparam int DEPTH  = QUEUE_DEPTH_DEF;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  job_t              slots [DEPTH];
  logic [31:0]       now_ticks;
  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  occupancy;
  out_t              awaited_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 30)
      $display("[%0t] mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
               $time, what, results_checked, got, want);
    mismatches++;
  endtask

  task automatic expect_result(input logic [2:0] status, input logic [15:0] id,
                               input logic [15:0] rem, input logic [31:0] el,
                               input logic [31:0] idle, input logic [13:0] hund,
                               input logic last);
    out_t r;
    r.status          = status;
    r.time_now        = now_ticks;
    r.job_id_out      = id;
    r.remaining       = rem;
    r.elapsed         = el;
    r.idle_cycles     = idle;
    r.idle_hundredths = hund;
    r.last            = last;
    awaited_results.push_back(r);
  endtask

  // Apply one accepted request to the shadow queue and queue its results.
  task automatic schedule_item(input in_t item);
    job_t        j;
    int          t;
    int          n;
    int          s;
    logic [31:0] el;
    logic [31:0] idle;
    logic [63:0] q;
    logic [13:0] hund;
    case (item.mode)
      MODE_TICK: begin
        if (occupancy == 0) begin
          expect_result(ST_IDLE_TICK, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          j = slots[head];
          if (j.left != 0) j.left = j.left - 16'd1;
          slots[head] = j;
          if (j.left == 0) begin
            el   = now_ticks - j.start + 32'd1;
            idle = el - 32'(j.total);
            hund = '0;
            if (el != 0) begin
              q    = (64'(idle) * 64'd10000 + 64'(el >> 1)) / 64'(el);
              hund = (q > 64'd10000) ? HUND_SCALE : q[13:0];
            end
            expect_result(ST_JOB_DONE, j.id, '0, el, idle, hund, 1'b1);
            head      = SLOT_W'((int'(head) + 1) % DEPTH);
            occupancy = occupancy - 1'b1;
          end else begin
            // rotate the head job to the tail
            t = (int'(head) + int'(occupancy)) % DEPTH;
            expect_result(ST_BUSY_TICK, j.id, j.left, '0, '0, '0, 1'b1);
            slots[t] = j;
            head     = SLOT_W'((int'(head) + 1) % DEPTH);
          end
        end
        now_ticks = now_ticks + 32'd1;
      end
      MODE_ADD: begin
        if (item.job_cycles == 0) begin
          expect_result(ST_BAD_LENGTH, item.job_id, '0, '0, '0, '0, 1'b1);
        end else if (occupancy >= DEPTH) begin
          expect_result(ST_FULL, item.job_id, item.job_cycles, '0, '0, '0, 1'b1);
        end else begin
          t           = (int'(head) + int'(occupancy)) % DEPTH;
          j.id        = item.job_id;
          j.start     = now_ticks;
          j.total     = item.job_cycles;
          j.left      = item.job_cycles;
          slots[t]    = j;
          occupancy   = occupancy + 1'b1;
          expect_result(ST_ADDED, item.job_id, item.job_cycles, '0, '0, '0, 1'b1);
        end
      end
      MODE_LIST: begin
        if (occupancy == 0) begin
          expect_result(ST_LIST_EMPTY, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          n = (occupancy > MAX_RESULTS) ? MAX_RESULTS : int'(occupancy);
          for (int i = 0; i < n; i++) begin
            s = (int'(head) + i) % DEPTH;
            expect_result(ST_LIST_ENTRY, slots[s].id, slots[s].left, '0, '0, '0,
                          1'b1 ? (i == n - 1) : 1'b0);
          end
        end
      end
      default: ;  // unused mode: dropped without a result
    endcase
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch("unexpected result, status", 32'(got.status), '0);
      return;
    end
    want = awaited_results.pop_front();
    compare_field("status", 32'(got.status), 32'(want.status));
    compare_field("time_now", got.time_now, want.time_now);
    compare_field("job_id_out", 32'(got.job_id_out), 32'(want.job_id_out));
    compare_field("remaining", 32'(got.remaining), 32'(want.remaining));
    compare_field("elapsed", got.elapsed, want.elapsed);
    compare_field("idle_cycles", got.idle_cycles, want.idle_cycles);
    compare_field("idle_hundredths", 32'(got.idle_hundredths),
                  32'(want.idle_hundredths));
    compare_field("last", 32'(got.last), 32'(want.last));
    if (want.status == ST_JOB_DONE) jobs_finished++;
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      now_ticks = '0;
      head      = '0;
      occupancy = '0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) schedule_item(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    results_outstanding = awaited_results.size();
  end

endmodule

// ----- dv/tb_round_robin_job_scheduler_core.sv -----
// Testbench top for the round-robin job scheduler core: clock, reset,
// request stimulus and result-side stalls; checking is done by the checker.
// Depends on rrjs_pkg, round_robin_job_scheduler_core and the checker module.
`timescale 1ns / 100ps
module tb_round_robin_job_scheduler_core;
  import rrjs_pkg::*;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int   mismatches;
  int   results_outstanding;
  int   results_checked;
  int   jobs_finished;
  logic quiet     = 1'b0;
  int   stall_left = 0;
  int   stall_roll;
  int   requests_sent = 0;

  always #4 clk = ~clk;

  round_robin_job_scheduler_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  round_robin_job_scheduler_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data           (out_data),
    .mismatches         (mismatches),
    .results_outstanding(results_outstanding),
    .results_checked    (results_checked),
    .jobs_finished      (jobs_finished)
  );

  // Result-side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    stall_roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (quiet || stall_roll >= 12) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left <= (stall_roll < 2) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    end
  end

  function automatic in_t make_request(input logic [1:0] mode, input logic [15:0] id,
                                       input logic [15:0] cycles);
    in_t r;
    r.mode       = mode;
    r.job_id     = id;
    r.job_cycles = cycles;
    return r;
  endfunction

  // Drive one request and hold it until the transfer completes.
  task automatic send_request(input in_t item);
    int   gap;
    int   roll;
    logic taken;
    roll = $urandom_range(0, 99);
    gap  = quiet ? 0 : (roll < 70) ? 0 : (roll < 95) ? $urandom_range(1, 3)
                                                     : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
  endtask

  initial begin
    in_t item;
    int  roll;
    int  counted;
    logic fill_phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queue, refusals, ignored mode, full queue, long list.
    send_request(make_request(MODE_LIST, 16'h0000, 16'h0000));
    send_request(make_request(MODE_TICK, 16'hFFFF, 16'hFFFF));
    send_request(make_request(MODE_ADD, 16'hFFFF, 16'h0000));
    send_request(make_request(MODE_NONE, 16'hA5A5, 16'h5A5A));
    send_request(make_request(MODE_ADD, 16'h0000, 16'h0001));
    send_request(make_request(MODE_ADD, 16'hFFFF, 16'h0003));
    send_request(make_request(MODE_LIST, 16'h1234, 16'h0000));
    for (int i = 2; i < QUEUE_DEPTH_DEF; i++)
      send_request(make_request(MODE_ADD, 16'($urandom), 16'($urandom_range(1, 4))));
    // full queue; a zero length is refused as bad length even when full
    send_request(make_request(MODE_ADD, 16'h8001, 16'hFFFF));
    send_request(make_request(MODE_ADD, 16'h7FFE, 16'h0000));
    send_request(make_request(MODE_LIST, 16'h0000, 16'h0000));
    send_request(make_request(MODE_TICK, 16'h0000, 16'h0000));
    send_request(make_request(MODE_TICK, 16'h0000, 16'h0000));

    // Hold off until every result of the directed part has arrived.
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_outstanding == 0);
    @(posedge clk);

    counted = 0;
    while (counted < 95) begin
      quiet      = (counted >= 50 && counted < 70);
      fill_phase = ((counted / 30) % 2) == 0;
      roll       = $urandom_range(0, 99);
      if (roll < 2)
        item = make_request(MODE_NONE, 16'($urandom), 16'($urandom));
      else if (roll < 4)
        item = make_request(MODE_ADD, 16'($urandom), 16'h0000);
      else if (roll < 12)
        item = make_request(MODE_LIST, 16'($urandom), 16'($urandom));
      else if (roll < (fill_phase ? 62 : 40))
        item = make_request(MODE_ADD, 16'($urandom),
                            ($urandom_range(0, 24) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(1, 6)));
      else
        item = make_request(MODE_TICK, 16'($urandom), 16'($urandom));
      send_request(item);
      if (item.mode != MODE_NONE) counted++;
      if (counted == 80 && item.mode != MODE_NONE) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_outstanding == 0);
        @(posedge clk);
      end
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_outstanding == 0);
    repeat (64) @(posedge clk);

    $display("Run covered %0d requests, %0d results checked, %0d jobs completed",
             requests_sent, results_checked, jobs_finished);
    if (mismatches == 0 && results_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still outstanding", results_outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule
